// ----- rtl/apt_pkg.sv -----
// shared types and constants for the affine point transform block
`default_nettype none

package apt_pkg;

	// coordinate and coefficient formats
	localparam int unsigned COORD_W = 32;
	localparam int unsigned COEFF_W = 16;
	localparam int unsigned ROW_W   = 3 * COEFF_W;
	localparam int unsigned AXES    = 3;

	// point minus translation keeps one extra bit
	localparam int unsigned OPND_W  = COORD_W + 1;
	localparam int unsigned PROD_W  = COEFF_W + OPND_W;
	// three products plus the scaled translation, with headroom
	localparam int unsigned ACC_W   = PROD_W + 3;

	localparam int unsigned IDX_W   = 3;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_ROW0    = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW1    = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW2    = 3'd2;
	localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_SHIFT_Z = 3'd5;

	// item opcodes
	localparam logic OP_FORWARD = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEFF_W-1:0] coeff_t;

	// one lane's finished coordinate
	typedef struct packed {
		coord_t val;
		logic   ovf;
	} lane_res_t;

endpackage

`default_nettype wire

// ----- rtl/affine_point_transform_core.sv -----
// top level: configuration registers, valid pipeline, three coordinate lanes
//
// Usage:
//   Input channel (in_valid/in_ready) carries one point per item: op selects
//   forward (R*p + t) or inverse (transpose(R) * (p - t)); px, py, pz are
//   signed Q16.16. Output channel (out_valid/out_ready) returns qx, qy, qz,
//   saturated to signed Q16.16, and overflow when any coordinate clamped.
//   Each coordinate is computed in its own lane; the output stage merges them.
//   From acceptance to out_valid an item passes the operand select, multiply,
//   sum, shift/saturate and output registers in that order.
//   Throughput is one item per cycle; the pipeline is limited by nothing but
//   the output register, so it accepts an item every cycle that the output
//   is empty or being taken.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline holds and in_ready drops in the same cycle.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0..2 matrix
//   rows, 3..5 translation); indexes 6 and 7 are ignored. Write only while idle.
//   Reset clears the pipeline, loads the identity matrix and zero translation.
`default_nettype none

module affine_point_transform_core
	import apt_pkg::*;
#(
	parameter int unsigned COEFF_FRAC_BITS = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [ROW_W-1:0]   cfg_data,
	// input items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	input  wire coord_t             px,
	input  wire coord_t             py,
	input  wire coord_t             pz,
	// result items
	output logic                    out_valid,
	input  wire logic               out_ready,
	output coord_t                  qx,
	output coord_t                  qy,
	output coord_t                  qz,
	output logic                    overflow
);

	localparam logic [COEFF_W-1:0] COEFF_ONE = COEFF_W'(1 << COEFF_FRAC_BITS);

	logic [ROW_W-1:0] row_q   [AXES];
	coord_t           shift_q [AXES];
	coeff_t           c_row   [AXES][AXES];
	coeff_t           c_col   [AXES][AXES];
	coord_t           p_vec   [AXES];
	lane_res_t        lane_res [AXES];
	logic             advance;
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic             v_s4;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= ROW_W'(COEFF_ONE);
			row_q[1]   <= ROW_W'(COEFF_ONE) << COEFF_W;
			row_q[2]   <= ROW_W'(COEFF_ONE) << (2 * COEFF_W);
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0:    row_q[0]   <= cfg_data;
				REG_ROW1:    row_q[1]   <= cfg_data;
				REG_ROW2:    row_q[2]   <= cfg_data;
				REG_SHIFT_X: shift_q[0] <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Y: shift_q[1] <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Z: shift_q[2] <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// matrix unpacking: rows for forward, columns for inverse
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			for (int j = 0; j < AXES; j++) begin
				c_row[i][j] = row_q[i][j*COEFF_W +: COEFF_W];
				c_col[i][j] = row_q[j][i*COEFF_W +: COEFF_W];
			end
		end
	end

	assign p_vec[0] = px;
	assign p_vec[1] = py;
	assign p_vec[2] = pz;

	// whole pipeline moves unless a result waits on a stalled receiver
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// one lane per output coordinate
	for (genvar g = 0; g < AXES; g++) begin : g_lane
		apt_lane #(
			.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.advance(advance),
			.op     (op),
			.p      (p_vec),
			.t      (shift_q),
			.t_own  (shift_q[g]),
			.c_row  (c_row[g]),
			.c_col  (c_col[g]),
			.res_s4 (lane_res[g])
		);
	end

	// merge lanes into the output register
	apt_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s4 (v_s4),
		.lane_res (lane_res),
		.out_valid(out_valid),
		.qx       (qx),
		.qy       (qy),
		.qz       (qz),
		.overflow (overflow)
	);

	// an overflow flag means at least one coordinate sits on a bound
	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |->
			(qx == 32'sh7fffffff || qx == -32'sh80000000 ||
			 qy == 32'sh7fffffff || qy == -32'sh80000000 ||
			 qz == 32'sh7fffffff || qz == -32'sh80000000))
		else $error("overflow set with no saturated coordinate");

	// an accepted item reaches the output when the pipeline keeps advancing
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 advance ##1 advance ##1 advance ##1 advance
			|=> out_valid)
		else $error("item lost in pipeline");

	// nothing appears at the output without an item in the last stage
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s4))
		else $error("result without item");

endmodule

`default_nettype wire

// ----- rtl/apt_lane.sv -----
// one output coordinate: operand select, three multiplies, sum, shift and saturate
`default_nettype none

module apt_lane
	import apt_pkg::*;
#(
	parameter int unsigned COEFF_FRAC_BITS = 12
) (
	input  wire logic      clk,
	input  wire logic      advance,
	input  wire logic      op,
	input  wire coord_t    p     [AXES],
	input  wire coord_t    t     [AXES],
	input  wire coord_t    t_own,
	input  wire coeff_t    c_row [AXES],
	input  wire coeff_t    c_col [AXES],
	output lane_res_t      res_s4
);

	logic signed [OPND_W-1:0] opnd_d  [AXES];
	logic signed [OPND_W-1:0] opnd_s1 [AXES];
	coeff_t                   coef_s1 [AXES];
	coord_t                   tadd_s1;
	logic signed [PROD_W-1:0] prod_s2 [AXES];
	coord_t                   tadd_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [ACC_W-1:0]  shifted;
	logic [ACC_W-COORD_W:0]   hi_bits;
	lane_res_t                res_d;

	// forward uses the point, inverse the point minus translation
	always_comb begin
		for (int j = 0; j < AXES; j++) begin
			if (op == OP_INVERSE) begin
				opnd_d[j] = OPND_W'($signed(p[j])) - OPND_W'($signed(t[j]));
			end else begin
				opnd_d[j] = OPND_W'($signed(p[j]));
			end
		end
	end

	// stage 1: operands and coefficients (row or column of the matrix)
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int j = 0; j < AXES; j++) begin
				opnd_s1[j] <= opnd_d[j];
				coef_s1[j] <= (op == OP_INVERSE) ? c_col[j] : c_row[j];
			end
			tadd_s1 <= (op == OP_INVERSE) ? coord_t'(0) : t_own;
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int j = 0; j < AXES; j++) begin
				prod_s2[j] <= PROD_W'($signed(coef_s1[j])) * PROD_W'($signed(opnd_s1[j]));
			end
			tadd_s2 <= tadd_s1;
		end
	end

	// stage 3: wide sum with the translation scaled to the coefficient format
	always_comb begin
		acc_sum = ACC_W'($signed(prod_s2[0])) + ACC_W'($signed(prod_s2[1]))
			+ ACC_W'($signed(prod_s2[2]))
			+ (ACC_W'($signed(tadd_s2)) <<< COEFF_FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			acc_s3 <= acc_sum;
		end
	end

	// stage 4: floor shift, then clamp to 32 bits
	always_comb begin
		shifted = acc_s3 >>> COEFF_FRAC_BITS;
		hi_bits = shifted[ACC_W-1:COORD_W-1];
		if ((&hi_bits) || !(|hi_bits)) begin
			res_d.val = shifted[COORD_W-1:0];
			res_d.ovf = 1'b0;
		end else begin
			res_d.val = acc_s3[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
				: {1'b0, {(COORD_W-1){1'b1}}};
			res_d.ovf = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s4 <= res_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/apt_merge.sv -----
// output register: gathers the three lanes and combines their overflow flags
`default_nettype none

module apt_merge
	import apt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire logic      valid_s4,
	input  wire lane_res_t lane_res [AXES],
	output logic           out_valid,
	output coord_t         qx,
	output coord_t         qy,
	output coord_t         qz,
	output logic           overflow
);

	logic out_valid_q;

	// valid of the held item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s4;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			qx       <= lane_res[0].val;
			qy       <= lane_res[1].val;
			qz       <= lane_res[2].val;
			overflow <= lane_res[0].ovf | lane_res[1].ovf | lane_res[2].ovf;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
